/* design/escaped_frame_receiver_defines.svh */
// Assertion macros used by the escaped frame receiver.
`ifndef ESCAPED_FRAME_RECEIVER_DEFINES_SVH
`define ESCAPED_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, checked while out of reset.
`define EFR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define EFR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/efr_pkg.sv */
// Types and constants of the escaped frame receiver.
`default_nettype none

package efr_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned INDEX_W    = 10;
    localparam int unsigned LENGTH_W   = 11;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned S_TDATA_W  = 24;
    localparam int unsigned M_TDATA_W  = 32;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MARK     = 3'd0,
        REG_LITERAL  = 3'd1,
        REG_END      = 3'd2,
        REG_DATA_CMD = 3'd3,
        REG_FIN_CMD  = 3'd4,
        REG_JUMP_CMD = 3'd5
    } t_reg_idx;

    // Register reset values.
    localparam logic [BYTE_W-1:0] RST_MARK     = 8'd31;
    localparam logic [BYTE_W-1:0] RST_LITERAL  = 8'd31;
    localparam logic [BYTE_W-1:0] RST_END      = 8'd3;
    localparam logic [BYTE_W-1:0] RST_DATA_CMD = 8'd1;
    localparam logic [BYTE_W-1:0] RST_FIN_CMD  = 8'd2;
    localparam logic [BYTE_W-1:0] RST_JUMP_CMD = 8'd4;

    // Request kinds carried in the input tuser bit.
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Result fields as held between the update stage and the output register.
    typedef struct packed {
        logic                rd_sel;
        logic                done;
        logic [BYTE_W-1:0]   cmd;
        logic [LENGTH_W-1:0] len;
        logic                ovf;
        logic                fin;
    } t_result;

endpackage

`default_nettype wire

/* design/efr_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module efr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* design/escaped_frame_receiver.sv */
// Escaped frame receiver: removes mark-byte escaping from received serial bytes.
//
// Usage: each transfer on the slave stream is one request. tuser selects the kind:
// zero means tdata[7:0] is a received byte, one means tdata[17:8] indexes the
// frame store to read. Received plain bytes are appended to the frame store; a
// mark byte arms an escape, and the byte after it stores a literal, latches a
// command (clearing the fill count), or ends the frame; any other byte is dropped.
// Every request produces exactly one transfer on the master stream, in order,
// carrying the read byte (zero for received bytes), the latched command, the fill
// count, the overflow flag and the frame-finished flag; tlast is high when the
// byte ended a frame. Each result passes the update stage, where the frame store
// RAM's registered read port delivers the read byte, and then the output register.
// Throughput is one request per cycle while the master side takes results. When
// the master side stalls, the finished result waits in the output register and
// one more request is held in the update stage; after that the slave tready drops
// until the output is taken. A synchronous active-low reset clears the escape,
// fill count, command and finished flag and restores the default byte codes; the
// frame store is not cleared. Byte codes are written on the configuration channel,
// which is always ready; the user must write them only while the block is idle.
`default_nettype none

`include "escaped_frame_receiver_defines.svh"

module escaped_frame_receiver #(
    parameter int unsigned STORE_DEPTH = 1024
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Configuration write channel.
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [efr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [efr_pkg::BYTE_W-1:0]         i_cfg_data,
    // Slave stream: requests.
    input  wire logic                               i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // tdata: [7:0] rx_byte, [17:8] read_index, [23:18] zero
    input  wire logic [efr_pkg::S_TDATA_W-1:0]      i_s_axis_tdata,
    // tuser: [0] req_type
    input  wire logic                               i_s_axis_tuser,
    // Master stream: results.
    output logic                                    o_m_axis_tvalid,
    input  wire logic                               i_m_axis_tready,
    // tdata: [7:0] read_data, [15:8] frame_command, [26:16] frame_length,
    //        [27] overflow, [28] finished_flag, [31:29] zero
    output logic [efr_pkg::M_TDATA_W-1:0]           o_m_axis_tdata,
    // tlast: frame_done
    output logic                                    o_m_axis_tlast
);

    localparam int unsigned AW = $clog2(STORE_DEPTH);
    localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(STORE_DEPTH);

    // Byte codes.
    logic [efr_pkg::BYTE_W-1:0] r_mark, r_literal, r_end;
    logic [efr_pkg::BYTE_W-1:0] r_data_cmd, r_fin_cmd, r_jump_cmd;

    // Deframer state.
    logic                        r_escape, n_escape;
    logic [CW-1:0]               r_count, n_count;
    logic [efr_pkg::BYTE_W-1:0]  r_command, n_command;
    logic                        r_finished, n_finished;

    // Update stage and output register.
    logic                        r_s1_valid;
    efr_pkg::t_result            r_s1, n_s1;
    logic                        r_m_valid;
    logic [efr_pkg::M_TDATA_W-1:0] r_m_data;
    logic                        r_m_last;

    logic                        s_accept;
    logic                        s1_advance;
    logic                        req_read;
    logic [efr_pkg::BYTE_W-1:0]  rx_byte;
    logic [efr_pkg::INDEX_W-1:0] read_index;
    logic                        store_en;
    logic [efr_pkg::BYTE_W-1:0]  store_val;
    logic                        do_store;
    logic                        done;
    logic                        ovf;
    logic                        is_cmd;
    logic [efr_pkg::BYTE_W-1:0]  ram_rdata;
    logic [efr_pkg::BYTE_W-1:0]  read_data;

    assign o_cfg_ready = 1'b1;

    assign req_read   = (i_s_axis_tuser == efr_pkg::REQ_READ);
    assign rx_byte    = i_s_axis_tdata[7:0];
    assign read_index = i_s_axis_tdata[17:8];

    assign s1_advance      = r_s1_valid && (!r_m_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || s1_advance;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark     <= efr_pkg::RST_MARK;
            r_literal  <= efr_pkg::RST_LITERAL;
            r_end      <= efr_pkg::RST_END;
            r_data_cmd <= efr_pkg::RST_DATA_CMD;
            r_fin_cmd  <= efr_pkg::RST_FIN_CMD;
            r_jump_cmd <= efr_pkg::RST_JUMP_CMD;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                efr_pkg::REG_MARK:     r_mark     <= i_cfg_data;
                efr_pkg::REG_LITERAL:  r_literal  <= i_cfg_data;
                efr_pkg::REG_END:      r_end      <= i_cfg_data;
                efr_pkg::REG_DATA_CMD: r_data_cmd <= i_cfg_data;
                efr_pkg::REG_FIN_CMD:  r_fin_cmd  <= i_cfg_data;
                efr_pkg::REG_JUMP_CMD: r_jump_cmd <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign is_cmd = (rx_byte == r_data_cmd) || (rx_byte == r_fin_cmd)
                 || (rx_byte == r_jump_cmd);

    // Decode one request and compute the state after it. The code tests after a
    // mark follow a fixed priority: literal, then the commands, then end of frame.
    always_comb begin
        n_escape   = r_escape;
        n_count    = r_count;
        n_command  = r_command;
        n_finished = r_finished;
        do_store   = 1'b0;
        store_val  = rx_byte;
        done       = 1'b0;
        if (s_accept && !req_read) begin
            if (r_escape) begin
                n_escape = 1'b0;
                if (rx_byte == r_literal) begin
                    do_store  = 1'b1;
                    store_val = r_literal;
                end else if (is_cmd) begin
                    n_count    = '0;
                    n_command  = rx_byte;
                    n_finished = 1'b0;
                end else if (rx_byte == r_end) begin
                    n_finished = 1'b1;
                    done       = 1'b1;
                end
            end else if (rx_byte == r_mark) begin
                n_escape = 1'b1;
            end else begin
                do_store = 1'b1;
            end
        end
        // Appending to a full store drops the byte and wraps the count.
        store_en = 1'b0;
        ovf      = 1'b0;
        if (do_store) begin
            if (r_count == FULL_COUNT) begin
                n_count = '0;
                ovf     = 1'b1;
                if (r_escape) begin
                    n_finished = 1'b0;
                end
            end else begin
                store_en = 1'b1;
                n_count  = r_count + 1'b1;
            end
        end
        n_s1.rd_sel = req_read && (32'(read_index) < STORE_DEPTH);
        n_s1.done   = done;
        n_s1.cmd    = n_command;
        n_s1.len    = efr_pkg::LENGTH_W'(n_count);
        n_s1.ovf    = ovf;
        n_s1.fin    = n_finished;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_escape   <= 1'b0;
            r_count    <= '0;
            r_command  <= '0;
            r_finished <= 1'b0;
        end else begin
            r_escape   <= n_escape;
            r_count    <= n_count;
            r_command  <= n_command;
            r_finished <= n_finished;
        end
    end

    // Frame store. A read and a write never fall in the same cycle, as each request
    // is one or the other, so no forwarding is needed. The read register only loads on
    // a read request, which keeps its data stable while the result waits in stage one.
    efr_ram #(
        .WIDTH (efr_pkg::BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_en),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (store_val),
        .i_re    (s_accept && req_read),
        .i_raddr (AW'(read_index)),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1 <= n_s1;
        end
    end

    assign read_data = r_s1.rd_sel ? ram_rdata : '0;

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s1_advance) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_m_data <= {3'b000, r_s1.fin, r_s1.ovf, r_s1.len, r_s1.cmd, read_data};
            r_m_last <= r_s1.done;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tlast  = r_m_last;

    // The fill count never passes the store depth.
    `EFR_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FULL_COUNT, "fill count beyond store depth")
    // A stored byte advances the fill count by exactly one.
    `EFR_ASSERT_NEXT(a_store_step, i_clk, i_rst_n, store_en, r_count == $past(r_count) + 1'b1, "fill count did not step on a store")
    // An overflow result always reports an empty frame.
    `EFR_ASSERT_NOW(a_ovf_len, i_clk, i_rst_n, r_m_valid && r_m_data[27], r_m_data[26:16] == '0, "overflow with nonzero length")
    // A frame end always reports the finished flag.
    `EFR_ASSERT_NOW(a_done_fin, i_clk, i_rst_n, r_m_valid && r_m_last, r_m_data[28], "frame end without finished flag")
    // A stalled update stage blocks new requests.
    `EFR_ASSERT_NOW(a_stall_block, i_clk, i_rst_n, r_s1_valid && !s1_advance, !o_s_axis_tready, "request taken over a stalled stage")

endmodule

`default_nettype wire
